/* hw/rtl/wstc_pkg.sv */
package wstc_pkg;

  // Field widths
  localparam int SPEED_W  = 16;
  localparam int RPM_W    = 16;
  localparam int TRQ_W    = 16;
  localparam int LIMIT_W  = 12;
  localparam int GAIN_W   = 16;
  localparam int RADIUS_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Fixed-point constants
  localparam logic [SPEED_W-1:0]  SPEED_FLOOR_MM_S = 16'd500;
  localparam logic [20:0]         OMEGA_K_Q24      = 21'd1756906;  // 2*pi/60 in Q24
  localparam logic signed [16:0]  HYST_Q12         = 17'sd123;     // 0.03 in Q12
  localparam logic signed [17:0]  SLIP_MIN_Q12     = -18'sd4096;   // -1.0
  localparam logic signed [17:0]  SLIP_MAX_Q12     = 18'sd32768;   // +8.0
  localparam logic [32:0]         ONE_Q20          = 33'd1048576;

  // Shared divider: 16 quotient bits per run
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Register reset values
  localparam logic [LIMIT_W-1:0]  SLIP_LIMIT_RST   = 12'd492;
  localparam logic [GAIN_W-1:0]   CUT_GAIN_RST     = 16'd3072;
  localparam logic [RADIUS_W-1:0] WHEEL_RADIUS_RST = 10'd230;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLIP_LIMIT   = 2'd0,
    REG_CUT_GAIN     = 2'd1,
    REG_WHEEL_RADIUS = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic        [SPEED_W-1:0] vehicle_speed_mm_s;
    logic signed [RPM_W-1:0]   left_wheel_rpm;
    logic signed [RPM_W-1:0]   right_wheel_rpm;
    logic signed [TRQ_W-1:0]   left_torque_in;
    logic signed [TRQ_W-1:0]   right_torque_in;
  } in_word_t;

  typedef struct packed {
    logic signed [TRQ_W-1:0] left_torque_out;
    logic signed [TRQ_W-1:0] right_torque_out;
    logic                    left_cut_flag;
    logic                    right_cut_flag;
  } out_word_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  slip_limit_q12;
    logic [GAIN_W-1:0]   cut_gain_q8;
    logic [RADIUS_W-1:0] wheel_radius_mm;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture input word
    logic mul_radius;  // rpm * radius
    logic mul_omega;   // * 2*pi/60
    logic slip_setup;  // form numerator, load divider
    logic div_step;    // one restoring divide step
    logic slip_done;   // clamp slip, update flag
    logic mul_gain;    // gain * excess slip
    logic trq_setup;   // load divider for torque cut
    logic out_load;    // move result into output register
  } dp_cmd_t;

endpackage

/* hw/rtl/wstc_lane.sv */
module wstc_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  wstc_pkg::dp_cmd_t               cmd,
  input  wstc_pkg::cfg_t                  cfg,
  input  logic        [wstc_pkg::SPEED_W-1:0] speed_mm_s,
  input  logic signed [wstc_pkg::RPM_W-1:0]   wheel_rpm,
  input  logic signed [wstc_pkg::TRQ_W-1:0]   torque_in,
  output logic signed [wstc_pkg::TRQ_W-1:0]   torque_out,
  output logic                            cut_flag
);
  import wstc_pkg::*;

  logic        [SPEED_W-1:0] v;
  logic signed [RPM_W-1:0]   rpm;
  logic signed [TRQ_W-1:0]   trq;
  logic signed [26:0]        p1;
  logic signed [48:0]        p2;
  logic                      neg;
  logic                      sat;
  logic [47:0]               r;
  logic [47:0]               ds;
  logic [DIV_STEPS-1:0]      q;
  logic signed [16:0]        slip;
  logic                      cut;
  logic [31:0]               gp;
  logic                      flag;

  logic signed [48:0] num;
  logic signed [48:0] num_neg;
  logic [47:0]        mag;
  logic [48:0]        diff;
  logic signed [17:0] qs;
  logic signed [17:0] sq;
  logic signed [17:0] slip_sat;
  logic signed [16:0] slip_next;
  logic signed [16:0] lim17;
  logic signed [16:0] lo17;
  logic signed [16:0] excess;
  logic [32:0]        den;
  logic               over;
  logic               under;

  // Slip numerator: wheel speed Q24 minus vehicle speed Q24
  assign num     = p2 - $signed({9'b0, v, 24'b0});
  assign num_neg = -num;
  assign mag     = num[48] ? num_neg[47:0] : num[47:0];

  // Restoring divide step
  assign diff = {1'b0, r} - {1'b0, ds};

  // Signed, saturated slip from quotient magnitude
  assign qs = $signed({2'b0, q});
  assign sq = neg ? -qs : qs;
  always_comb begin
    if (sat) begin
      slip_sat = neg ? SLIP_MIN_Q12 : SLIP_MAX_Q12;
    end else if (sq < SLIP_MIN_Q12) begin
      slip_sat = SLIP_MIN_Q12;
    end else if (sq > SLIP_MAX_Q12) begin
      slip_sat = SLIP_MAX_Q12;
    end else begin
      slip_sat = sq;
    end
  end
  assign slip_next = slip_sat[16:0];

  // Hysteresis thresholds
  assign lim17  = $signed({5'b0, cfg.slip_limit_q12});
  assign lo17   = lim17 - HYST_Q12;
  assign over   = slip_next > lim17;
  assign under  = slip_next < lo17;
  assign excess = slip - lim17;
  assign den    = ONE_Q20 + {1'b0, gp};

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v   <= (speed_mm_s < SPEED_FLOOR_MM_S) ? SPEED_FLOOR_MM_S : speed_mm_s;
      rpm <= wheel_rpm;
      trq <= torque_in;
    end
    if (cmd.mul_radius) begin
      p1 <= rpm * $signed({1'b0, cfg.wheel_radius_mm});
    end
    if (cmd.mul_omega) begin
      p2 <= p1 * $signed({1'b0, OMEGA_K_Q24});
    end
    if (cmd.slip_setup) begin
      neg <= num[48];
      sat <= mag >= {4'b0, v, 28'b0};
      r   <= mag;
      ds  <= {5'b0, v, 27'b0};
      q   <= '0;
    end
    if (cmd.trq_setup) begin
      r  <= {13'b0, trq[TRQ_W-2:0], 20'b0};
      ds <= {den, 15'b0};
      q  <= '0;
    end
    if (cmd.div_step) begin
      if (!diff[48]) begin
        r <= diff[47:0];
      end
      q  <= {q[DIV_STEPS-2:0], !diff[48]};
      ds <= {1'b0, ds[47:1]};
    end
    if (cmd.slip_done) begin
      slip <= slip_next;
      cut  <= over && !trq[TRQ_W-1] && (trq != '0);
    end
    if (cmd.mul_gain) begin
      gp <= cfg.cut_gain_q8 * excess[15:0];
    end
  end

  // Hysteresis flag
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (cmd.slip_done) begin
      if (over) begin
        flag <= 1'b1;
      end else if (under) begin
        flag <= 1'b0;
      end
    end
  end

  assign torque_out = cut ? $signed({1'b0, q[TRQ_W-2:0]}) : trq;
  assign cut_flag   = flag;

endmodule

/* hw/rtl/wstc_ctrl.sv */
module wstc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output wstc_pkg::dp_cmd_t cmd
);
  import wstc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_MUL1    = 10'b00_0000_0010,
    S_MUL2    = 10'b00_0000_0100,
    S_SSETUP  = 10'b00_0000_1000,
    S_SDIV    = 10'b00_0001_0000,
    S_SLIP    = 10'b00_0010_0000,
    S_GMUL    = 10'b00_0100_0000,
    S_TSETUP  = 10'b00_1000_0000,
    S_TDIV    = 10'b01_0000_0000,
    S_OUT     = 10'b10_0000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_radius = 1'b1;
        state_next     = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_omega = 1'b1;
        state_next    = S_SSETUP;
      end
      S_SSETUP: begin
        cmd.slip_setup = 1'b1;
        state_next     = S_SDIV;
      end
      S_SDIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_SLIP;
        end
      end
      S_SLIP: begin
        cmd.slip_done = 1'b1;
        state_next    = S_GMUL;
      end
      S_GMUL: begin
        cmd.mul_gain = 1'b1;
        state_next   = S_TSETUP;
      end
      S_TSETUP: begin
        cmd.trq_setup = 1'b1;
        state_next    = S_TDIV;
      end
      S_TDIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count divide steps
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.slip_setup || cmd.trq_setup) begin
      cnt <= CNT_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/wheel_slip_torque_cut.sv */
// Rear-axle slip-ratio traction control. Each input word carries vehicle speed,
// both rear wheel speeds and the requested rear torques; each produces exactly
// one output word with the attenuated torques and the two hysteresis flags.
// Both wheels run in parallel lanes, and each lane has one restoring divider
// that is used twice per word: 16 steps for the slip ratio and 16 steps for the
// torque cut. With the setup and multiply steps, in_stall stays high from the
// acceptance of a word until its result is loaded into the output register,
// so no new word is taken while one is in flight; a stalled output word holds
// the block in its final step until the previous word is taken. Registers
// must be written through the wr_en/wr_index/wr_data port only while no word
// is in flight; the block does not enforce this. Unknown indexes are ignored.
module wheel_slip_torque_cut (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wstc_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wstc_pkg::out_word_t                 out_word,
  input  logic                                wr_en,
  input  logic [wstc_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [wstc_pkg::CFG_DATA_W-1:0]     wr_data
);
  import wstc_pkg::*;

  cfg_t                    cfg;
  dp_cmd_t                 cmd;
  logic signed [TRQ_W-1:0] left_trq;
  logic signed [TRQ_W-1:0] right_trq;
  logic                    left_flag;
  logic                    right_flag;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slip_limit_q12  <= SLIP_LIMIT_RST;
      cfg.cut_gain_q8     <= CUT_GAIN_RST;
      cfg.wheel_radius_mm <= WHEEL_RADIUS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SLIP_LIMIT:   cfg.slip_limit_q12  <= wr_data[LIMIT_W-1:0];
        REG_CUT_GAIN:     cfg.cut_gain_q8     <= wr_data[GAIN_W-1:0];
        REG_WHEEL_RADIUS: cfg.wheel_radius_mm <= wr_data[RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wstc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  wstc_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .speed_mm_s (in_word.vehicle_speed_mm_s),
    .wheel_rpm  (in_word.left_wheel_rpm),
    .torque_in  (in_word.left_torque_in),
    .torque_out (left_trq),
    .cut_flag   (left_flag)
  );

  wstc_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .speed_mm_s (in_word.vehicle_speed_mm_s),
    .wheel_rpm  (in_word.right_wheel_rpm),
    .torque_in  (in_word.right_torque_in),
    .torque_out (right_trq),
    .cut_flag   (right_flag)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.left_torque_out  <= left_trq;
      out_word.right_torque_out <= right_trq;
      out_word.left_cut_flag    <= left_flag;
      out_word.right_cut_flag   <= right_flag;
    end
  end

  // An accepted word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  // A new output word appears only as the controller returns to idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("output word raised while controller still busy");

  // A new output word always follows a busy period
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word raised without work in progress");

endmodule

/* dv/testbench.sv */
module testbench;
  import wstc_pkg::*;

  localparam longint OMEGA_Q24 = 1756906;  // 2*pi/60 in Q24
  localparam longint V_FLOOR   = 500;
  localparam longint HYST      = 123;
  localparam longint SLIP_LO   = -4096;
  localparam longint SLIP_HI   = 32768;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 70;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
    int        sel;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;

  cfg_t cfg_now;
  bit left_latched;
  bit right_latched;
  out_word_t cut_results_q[$];
  int errors = 0;
  int words_seen = 0;
  bit calm = 1'b0;

  wheel_slip_torque_cut dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #10 clk = ~clk;

  function automatic cfg_t settings(int limit, int gain, int radius);
    cfg_t c;
    c.slip_limit_q12  = limit[LIMIT_W-1:0];
    c.cut_gain_q8     = gain[GAIN_W-1:0];
    c.wheel_radius_mm = radius[RADIUS_W-1:0];
    return c;
  endfunction

  // Slip ratio in Q12 for one wheel, saturated to -1..+8
  function automatic longint slip_q12_of(longint rpm, longint v);
    longint wheel, num, s;
    wheel = rpm * longint'(cfg_now.wheel_radius_mm) * OMEGA_Q24;
    num = wheel - (v <<< 24);
    s = num / (v * 4096);
    if (s < SLIP_LO) s = SLIP_LO;
    if (s > SLIP_HI) s = SLIP_HI;
    return s;
  endfunction

  function automatic bit next_flag(longint slip, bit flag);
    longint lim;
    lim = longint'(cfg_now.slip_limit_q12);
    if (slip > lim) return 1'b1;
    if (slip < lim - HYST) return 1'b0;
    return flag;
  endfunction

  // Divide a positive torque by 1 + gain * excess slip
  function automatic longint cut_torque(longint slip, longint trq);
    longint lim, den;
    lim = longint'(cfg_now.slip_limit_q12);
    if (slip > lim && trq > 0) begin
      den = 1048576 + longint'(cfg_now.cut_gain_q8) * (slip - lim);
      return (trq * 1048576) / den;
    end
    return trq;
  endfunction

  // Work out the output word and advance both hysteresis flags
  function automatic out_word_t traction_predict(in_word_t w);
    out_word_t o;
    longint v, ls, rs, lt, rt;
    v = longint'(w.vehicle_speed_mm_s);
    if (v < V_FLOOR) v = V_FLOOR;
    ls = slip_q12_of(longint'($signed(w.left_wheel_rpm)), v);
    rs = slip_q12_of(longint'($signed(w.right_wheel_rpm)), v);
    left_latched = next_flag(ls, left_latched);
    right_latched = next_flag(rs, right_latched);
    lt = cut_torque(ls, longint'($signed(w.left_torque_in)));
    rt = cut_torque(rs, longint'($signed(w.right_torque_in)));
    o.left_torque_out  = lt[15:0];
    o.right_torque_out = rt[15:0];
    o.left_cut_flag    = left_latched;
    o.right_cut_flag   = right_latched;
    return o;
  endfunction

  function automatic dir_row_t row(int sel, int v, int lr, int rr, int lt, int rt,
                                   bit typed, int elt, int ert, bit elf, bit erf);
    dir_row_t r;
    r.sel = sel;
    r.w.vehicle_speed_mm_s = v[15:0];
    r.w.left_wheel_rpm     = lr[15:0];
    r.w.right_wheel_rpm    = rr[15:0];
    r.w.left_torque_in     = lt[15:0];
    r.w.right_torque_in    = rt[15:0];
    r.typed = typed;
    r.want.left_torque_out  = elt[15:0];
    r.want.right_torque_out = ert[15:0];
    r.want.left_cut_flag    = elf;
    r.want.right_cut_flag   = erf;
    return r;
  endfunction

  // Wheel speed that lands near a chosen slip at the current radius
  function automatic logic [15:0] aim_rpm(longint v, longint s);
    longint rpm;
    if (cfg_now.wheel_radius_mm == 0) return 16'($urandom);
    rpm = (v * (4096 + s) * 16777216) /
          (4096 * longint'(cfg_now.wheel_radius_mm) * OMEGA_Q24);
    rpm = rpm + longint'($urandom_range(0, 4)) - 2;
    if (rpm > 32767) rpm = 32767;
    if (rpm < -32768) rpm = -32768;
    return rpm[15:0];
  endfunction

  function automatic longint pick_slip();
    if ($urandom_range(0, 3) == 0) return longint'($urandom_range(0, 12000)) - 4096;
    return longint'(cfg_now.slip_limit_q12) + longint'($urandom_range(0, 700)) - 350;
  endfunction

  function automatic logic [15:0] pick_torque();
    int t;
    if ($urandom_range(0, 9) < 8) t = $urandom_range(1, 32767);
    else t = $urandom;
    return t[15:0];
  endfunction

  // Mostly plausible wheel speeds around the slip limit, the rest raw noise
  function automatic in_word_t make_item();
    in_word_t w;
    bit [95:0] raw;
    longint v;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 9) == 0) v = longint'($urandom_range(0, 600));
      else v = longint'($urandom_range(500, 40000));
      w.vehicle_speed_mm_s = v[15:0];
      if (v < V_FLOOR) v = V_FLOOR;
      w.left_wheel_rpm  = aim_rpm(v, pick_slip());
      w.right_wheel_rpm = aim_rpm(v, pick_slip());
      w.left_torque_in  = pick_torque();
      w.right_torque_in = pick_torque();
    end else begin
      raw = {$urandom, $urandom, $urandom};
      w = raw[79:0];
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then maybe idle
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t pred;
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = traction_predict(w);
    cut_results_q.push_back(typed ? want : pred);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every word in flight has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (cut_results_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers, with junk in the unused upper bits, plus an unknown index
  task automatic load_settings(input cfg_t c);
    logic [31:0] upper;
    upper = $urandom;
    wr_en <= 1'b1;
    wr_index <= REG_SLIP_LIMIT;
    wr_data <= {upper[3:0], c.slip_limit_q12};
    @(posedge clk);
    wr_index <= REG_CUT_GAIN;
    wr_data <= c.cut_gain_q8;
    @(posedge clk);
    wr_index <= REG_WHEEL_RADIUS;
    wr_data <= {upper[9:4], c.wheel_radius_mm};
    @(posedge clk);
    wr_index <= REG_UNUSED;
    wr_data <= upper[31:16];
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_now = c;
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t exp_w;
    if (cut_results_q.size() == 0) begin
      $display("%0t unexpected word: expected none, got %h", $time, got);
      errors++;
      return;
    end
    exp_w = cut_results_q.pop_front();
    if (got.left_torque_out !== exp_w.left_torque_out) begin
      $display("%0t left_torque_out expected %0d got %0d", $time,
               exp_w.left_torque_out, got.left_torque_out);
      errors++;
    end
    if (got.right_torque_out !== exp_w.right_torque_out) begin
      $display("%0t right_torque_out expected %0d got %0d", $time,
               exp_w.right_torque_out, got.right_torque_out);
      errors++;
    end
    if (got.left_cut_flag !== exp_w.left_cut_flag) begin
      $display("%0t left_cut_flag expected %0b got %0b", $time,
               exp_w.left_cut_flag, got.left_cut_flag);
      errors++;
    end
    if (got.right_cut_flag !== exp_w.right_cut_flag) begin
      $display("%0t right_cut_flag expected %0b got %0b", $time,
               exp_w.right_cut_flag, got.right_cut_flag);
      errors++;
    end
  endtask

  // Take output words; stall in short bursts, once for a long stretch
  initial begin : receiver
    int hold;
    bit long_done;
    hold = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        check_word(out_word);
        words_seen++;
      end
      if (hold > 0) hold--;
      else if (!long_done && words_seen == 120) begin
        hold = 400;
        long_done = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 11);
      out_stall <= (hold > 0);
    end
  end

  initial begin : watchdog
    #5000000;
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    dir_row_t rows[$];
    cfg_t dir_cfg[5];
    cfg_t phase_cfg[$];
    int cur_sel;
    int waited;

    cfg_now = settings(int'(SLIP_LIMIT_RST), int'(CUT_GAIN_RST),
                       int'(WHEEL_RADIUS_RST));
    left_latched = 1'b0;
    right_latched = 1'b0;

    dir_cfg[0] = cfg_now;
    dir_cfg[1] = settings(492, 3072, 0);
    dir_cfg[2] = settings(492, 0, 230);
    dir_cfg[3] = settings(0, 65535, 1000);
    dir_cfg[4] = settings(4095, 65535, 1);

    // Values after reset, field extremes
    rows.push_back(row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    rows.push_back(row(0, 0, 0, 0, -32768, 32767, 1, -32768, 32767, 0, 0));
    rows.push_back(row(0, 65535, 0, 0, 32767, -32768, 1, 32767, -32768, 0, 0));
    rows.push_back(row(0, 0, 32767, -32768, -1, 1, 1, -1, 1, 1, 0));
    rows.push_back(row(0, 0, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0));
    // Slow vehicle around the speed floor
    rows.push_back(row(0, 499, 20, 21, 1000, 1000, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 500, 24, 25, 1000, -1000, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 1, 30, 30, 500, 500, 0, 0, 0, 0, 0));
    // Walk both wheels through set, hold, clear, hold
    rows.push_back(row(0, 10000, 470, 450, 20000, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 10000, 458, 458, 0, 20000, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 10000, 450, 470, 20000, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 10000, 458, 458, 0, 20000, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 65535, -32768, 32767, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 30000, 1500, 1400, 32767, 12345, 0, 0, 0, 0, 0));
    // Zero radius: slip pinned at -1
    rows.push_back(row(1, 20000, 32767, -32768, 32767, 32767, 1, 32767, 32767, 0, 0));
    rows.push_back(row(1, 0, 100, 100, 5, -5, 1, 5, -5, 0, 0));
    // Zero gain: torque passes though the flags set
    rows.push_back(row(2, 0, 32767, 32767, 32767, 32767, 1, 32767, 32767, 1, 1));
    rows.push_back(row(2, 10000, 600, 470, 1234, -1234, 0, 0, 0, 0, 0));
    // Register extremes
    rows.push_back(row(3, 5000, 100, 200, 32767, 100, 0, 0, 0, 0, 0));
    rows.push_back(row(4, 0, 32767, -32768, 32767, 32767, 0, 0, 0, 0, 0));

    phase_cfg.push_back(settings(int'(SLIP_LIMIT_RST), int'(CUT_GAIN_RST),
                                 int'(WHEEL_RADIUS_RST)));
    phase_cfg.push_back(settings(0, $urandom_range(0, 65535), $urandom_range(1, 1000)));
    phase_cfg.push_back(settings(4095, 65535, 230));
    phase_cfg.push_back(settings(492, 0, 230));
    phase_cfg.push_back(settings($urandom_range(0, 4095), 65535, 1));
    phase_cfg.push_back(settings($urandom_range(0, 4095), $urandom_range(0, 65535), 1000));
    phase_cfg.push_back(settings($urandom_range(0, 4095), $urandom_range(0, 65535), 0));
    phase_cfg.push_back(settings($urandom_range(0, 4095), $urandom_range(0, 65535),
                                 $urandom_range(1, 1000)));
    phase_cfg.push_back(settings($urandom_range(0, 1000), $urandom_range(0, 8000),
                                 $urandom_range(100, 400)));
    phase_cfg.push_back(settings(int'(SLIP_LIMIT_RST), int'(CUT_GAIN_RST),
                                 int'(WHEEL_RADIUS_RST)));

    // Hold reset
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed table
    cur_sel = 0;
    foreach (rows[i]) begin
      if (rows[i].sel != cur_sel) begin
        settle();
        load_settings(dir_cfg[rows[i].sel]);
        cur_sel = rows[i].sel;
      end
      send_word(rows[i].w, rows[i].typed, rows[i].want);
    end

    // Random phases; the last one runs with no idling
    foreach (phase_cfg[p]) begin
      settle();
      load_settings(phase_cfg[p]);
      if (p == phase_cfg.size() - 1) calm = 1'b1;
      repeat (ITEMS_PER_PHASE) send_word(make_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then let the block sit a while
    waited = 0;
    while (cut_results_q.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (cut_results_q.size() > 0) begin
      $display("%0t missing words: expected %0d more, got none", $time,
               cut_results_q.size());
      errors++;
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
